### rtl/core/chhmm_pkg.sv
// ============================================================================
// chhmm_pkg
// Shared types, register indexes, reset values and digit helpers for the
// 24-hour HH:MM clock with a set button.
// ============================================================================
package chhmm_pkg;

    // Field widths
    localparam int TPM_W    = 8;
    localparam int HOLD_W   = 7;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int SEG_W    = 7;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 48;

    // Register reset values
    localparam logic [TPM_W-1:0]  TPM_RESET       = 8'd60;
    localparam logic [HOLD_W-1:0] HOLD_FAST_RESET = 7'd100;
    localparam logic [HOLD_W-1:0] HOLD_REP_RESET  = 7'd10;
    localparam logic [HOLD_W-1:0] HOLD_MAX        = 7'd127;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICKS_PER_MINUTE = 2'd0,
        REG_HOLD_FAST        = 2'd1,
        REG_HOLD_REPEAT      = 2'd2
    } reg_index_t;

    // Time of day as four decimal digits
    typedef struct packed {
        logic [1:0] hr_tens;
        logic [3:0] hr_units;
        logic [2:0] min_tens;
        logic [3:0] min_units;
    } time_t;

    localparam time_t TIME_RESET = '{hr_tens: 2'd2, hr_units: 4'd2,
                                     min_tens: 3'd2, min_units: 4'd2};

    // Seven-segment codes for 0..9, bit 0 is segment a
    localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // Segment code of one digit; anything above nine shows blank.
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        code = '0;
        if (digit < 4'd10) begin
            code = SEG_TABLE[digit];
        end
        return code;
    endfunction

    // Advance the time by one minute, wrapping 23:59 to 00:00.
    function automatic time_t advance_minute(input time_t t);
        logic [4:0] mu;
        logic [3:0] mt;
        logic [4:0] hu;
        logic [2:0] ht;
        time_t      r;
        mu = {1'b0, t.min_units} + 5'd1;
        mt = {1'b0, t.min_tens};
        hu = {1'b0, t.hr_units};
        ht = {1'b0, t.hr_tens};
        if (mu > 5'd9) begin
            mu = 5'd0;
            mt = mt + 4'd1;
        end
        if (mt > 4'd5) begin
            mt = 4'd0;
            hu = hu + 5'd1;
        end
        if (hu > 5'd9) begin
            hu = 5'd0;
            ht = ht + 3'd1;
        end
        if (ht > 3'd2 || (ht == 3'd2 && hu > 5'd3)) begin
            ht = 3'd0;
            hu = 5'd0;
        end
        r.min_units = mu[3:0];
        r.min_tens  = mt[2:0];
        r.hr_units  = hu[3:0];
        r.hr_tens   = ht[1:0];
        return r;
    endfunction

endpackage

### rtl/core/clock_hhmm_with_set_button.sv
// ============================================================================
// clock_hhmm_with_set_button
// 24-hour HH:MM clock stepped by incoming tick items, with a set button
// that advances minutes on hold, and seven-segment codes for each digit.
// ============================================================================
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    button_low, button_confirm
//  m_        out        m_tvalid/m_tready    four digits, four segment codes
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item is taken per clock unless intake stops; its result appears in the
// output register on the next cycle. The output register is refilled in the
// cycle it is read. After a write to hold_repeat_ticks, a bit-serial remainder
// unit rebuilds the hold phase, during which neither item nor write is taken.
// aresetn is synchronous and active low; the time restarts at 22:22.
// A stalled m_tready holds the result and stops intake until it is taken.
module clock_hhmm_with_set_button (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [0] button_low, [1] button_confirm, [7:2] zero
    input  logic [chhmm_pkg::S_DATA_W-1:0]         s_tdata,
    // Result items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [1:0] hour_tens, [5:2] hour_units, [8:6] minute_tens,
    // [12:9] minute_units, [19:13] seg_hour_tens, [26:20] seg_hour_units,
    // [33:27] seg_minute_tens, [40:34] seg_minute_units, [47:41] zero
    output logic [chhmm_pkg::M_DATA_W-1:0]         m_tdata,
    // Configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [chhmm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [chhmm_pkg::CFG_W-1:0]            cfg_data
);

    typedef enum logic {
        ST_RUN,
        ST_MOD
    } state_t;

    state_t                               state_reg;
    logic [chhmm_pkg::TPM_W-1:0]          tpm_reg;
    logic [chhmm_pkg::HOLD_W-1:0]         fast_reg;
    logic [chhmm_pkg::HOLD_W-1:0]         rep_reg;
    logic [chhmm_pkg::TPM_W-1:0]          presc_reg;
    logic [chhmm_pkg::TPM_W-1:0]          presc_next;
    chhmm_pkg::time_t                     time_reg;
    chhmm_pkg::time_t                     time_next;
    chhmm_pkg::time_t                     time_tick;
    logic                                 latch_reg;
    logic                                 latch_next;
    logic [chhmm_pkg::HOLD_W-1:0]         hold_reg;
    logic [chhmm_pkg::HOLD_W-1:0]         hold_next;
    logic [chhmm_pkg::HOLD_W-1:0]         phase_reg;
    logic [chhmm_pkg::HOLD_W-1:0]         phase_next;
    logic [2:0]                           step_reg;
    logic [chhmm_pkg::HOLD_W-1:0]         rem_reg;
    logic [chhmm_pkg::HOLD_W-1:0]         rem_next;
    logic                                 m_tvalid_reg;
    logic [chhmm_pkg::M_DATA_W-1:0]       m_tdata_reg;
    logic [chhmm_pkg::M_DATA_W-1:0]       m_tdata_next;

    logic                                 s_accept;
    logic                                 cfg_accept;
    logic                                 pressed;
    logic                                 confirm;
    logic [chhmm_pkg::TPM_W:0]            presc_inc;
    logic                                 presc_wrap;
    logic [chhmm_pkg::HOLD_W:0]           phase_inc;
    logic                                 btn_advance;
    logic [chhmm_pkg::HOLD_W:0]           rem_shift;

    assign pressed  = s_tdata[0];
    assign confirm  = s_tdata[1];

    // Handshakes: intake stops while the result is stalled or the phase is rebuilt.
    assign s_tready   = (state_reg == ST_RUN) && (!m_tvalid_reg || m_tready);
    assign cfg_ready  = (state_reg == ST_RUN);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    // Prescaler and the minute advance it causes.
    always_comb begin
        presc_inc  = {1'b0, presc_reg} + 9'd1;
        presc_wrap = presc_inc >= {1'b0, tpm_reg};
        presc_next = presc_wrap ? '0 : presc_inc[chhmm_pkg::TPM_W-1:0];
        time_tick  = presc_wrap ? chhmm_pkg::advance_minute(time_reg) : time_reg;
    end

    // Button hold: latch, saturating hold count, and the count's phase
    // within the repeat period, kept so no runtime divide is needed.
    always_comb begin
        latch_next  = 1'b0;
        hold_next   = '0;
        phase_next  = '0;
        btn_advance = 1'b0;
        phase_inc   = {1'b0, phase_reg} + 8'd1;
        if (pressed) begin
            latch_next = latch_reg || (hold_reg == '0 && confirm);
            hold_next  = hold_reg;
            phase_next = phase_reg;
            if (latch_next) begin
                if (hold_reg < chhmm_pkg::HOLD_MAX) begin
                    hold_next  = hold_reg + 7'd1;
                    phase_next = (phase_inc == {1'b0, rep_reg}) ? '0
                                 : phase_inc[chhmm_pkg::HOLD_W-1:0];
                end
                btn_advance = (hold_next >= fast_reg) ||
                              (rep_reg != '0 && phase_next == '0);
            end
        end
        time_next = btn_advance ? chhmm_pkg::advance_minute(time_tick) : time_tick;
    end

    // Result payload: the digits before this item's update and their codes.
    always_comb begin
        m_tdata_next        = '0;
        m_tdata_next[1:0]   = time_reg.hr_tens;
        m_tdata_next[5:2]   = time_reg.hr_units;
        m_tdata_next[8:6]   = time_reg.min_tens;
        m_tdata_next[12:9]  = time_reg.min_units;
        m_tdata_next[19:13] = chhmm_pkg::seg_of({2'b00, time_reg.hr_tens});
        m_tdata_next[26:20] = chhmm_pkg::seg_of(time_reg.hr_units);
        m_tdata_next[33:27] = chhmm_pkg::seg_of({1'b0, time_reg.min_tens});
        m_tdata_next[40:34] = chhmm_pkg::seg_of(time_reg.min_units);
    end

    // One restoring remainder step: hold count modulo the repeat period.
    always_comb begin
        rem_shift = {rem_reg, hold_reg[step_reg]};
        rem_next  = rem_shift[chhmm_pkg::HOLD_W-1:0];
        if (rem_shift >= {1'b0, rep_reg}) begin
            rem_next = rem_shift[chhmm_pkg::HOLD_W-1:0] - rep_reg;
        end
    end

    // Control state, configuration registers, clock state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            tpm_reg      <= chhmm_pkg::TPM_RESET;
            fast_reg     <= chhmm_pkg::HOLD_FAST_RESET;
            rep_reg      <= chhmm_pkg::HOLD_REP_RESET;
            presc_reg    <= '0;
            time_reg     <= chhmm_pkg::TIME_RESET;
            latch_reg    <= 1'b0;
            hold_reg     <= '0;
            phase_reg    <= '0;
            step_reg     <= '0;
            rem_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end else begin
            case (state_reg)
                ST_RUN: begin
                    if (cfg_accept) begin
                        case (cfg_index)
                            chhmm_pkg::REG_TICKS_PER_MINUTE: begin
                                tpm_reg <= cfg_data;
                            end
                            chhmm_pkg::REG_HOLD_FAST: begin
                                fast_reg <= cfg_data[chhmm_pkg::HOLD_W-1:0];
                            end
                            chhmm_pkg::REG_HOLD_REPEAT: begin
                                rep_reg   <= cfg_data[chhmm_pkg::HOLD_W-1:0];
                                rem_reg   <= '0;
                                step_reg  <= 3'd6;
                                state_reg <= ST_MOD;
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (s_accept) begin
                        presc_reg <= presc_next;
                        time_reg  <= time_next;
                        latch_reg <= latch_next;
                        hold_reg  <= hold_next;
                        phase_reg <= phase_next;
                    end
                end
                ST_MOD: begin
                    rem_reg  <= rem_next;
                    step_reg <= step_reg - 3'd1;
                    if (step_reg == 3'd0) begin
                        phase_reg <= rem_next;
                        state_reg <= ST_RUN;
                    end
                end
                default: begin
                    state_reg <= ST_RUN;
                end
            endcase
            // Output register valid: filled on intake, emptied when read.
            if (s_accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // Output register payload, loaded with each accepted item.
            if (s_accept) begin
                m_tdata_reg <= m_tdata_next;
            end
        end
    end

endmodule

### rtl/core/chhmm_checker.sv
// ============================================================================
// chhmm_checker
// Port-level checks for the HH:MM clock, bound to the top level.
// ============================================================================
module chhmm_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [chhmm_pkg::M_DATA_W-1:0]     m_tdata
);

    // A stalled result keeps its payload.
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every accepted item shows a result in the following cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item produced no result");

    // Displayed digits form a valid 24-hour time and padding is zero.
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:41] == 7'd0 && m_tdata[1:0] <= 2'd2
                     && m_tdata[5:2] <= 4'd9 && m_tdata[8:6] <= 3'd5
                     && m_tdata[12:9] <= 4'd9
                     && !(m_tdata[1:0] == 2'd2 && m_tdata[5:2] > 4'd3))
        else $error("result digits out of range");

    // Segment codes match their digits.
    a_seg_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:13] == chhmm_pkg::seg_of({2'b00, m_tdata[1:0]})
                     && m_tdata[26:20] == chhmm_pkg::seg_of(m_tdata[5:2])
                     && m_tdata[33:27] == chhmm_pkg::seg_of({1'b0, m_tdata[8:6]})
                     && m_tdata[40:34] == chhmm_pkg::seg_of(m_tdata[12:9]))
        else $error("segment code does not match digit");

endmodule

bind clock_hhmm_with_set_button chhmm_checker u_chhmm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
